// ===== hdl/matrix_keypad_debounce_scanner_macros.svh =====
// Assertion macros shared by the keypad scanner modules.
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KPD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KPD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kpd_pkg.sv =====
// Shared types, constants and the key code table of the keypad scanner.
package kpd_pkg;

    localparam int ROWS    = 2;
    localparam int COLUMNS = 4;

    localparam int CODE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int CHECK_W = 4;
    localparam int SCAN_W  = 8;
    localparam int ROW_PITCH = 4;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd20;
    localparam logic [COUNT_W-1:0] LIMIT_MAX   = 7'd100;
    localparam logic [COUNT_W-1:0] PARK_OFFSET = 7'd10;

    typedef logic [CODE_W-1:0] t_code;

    typedef enum logic {
        REQ_SCAN = 1'b0,
        REQ_READ = 1'b1
    } t_req;

    // Row-major character codes: L D S R / E 2 U 1.
    localparam t_code CODE_TABLE [2][4] = '{
        '{8'h4C, 8'h44, 8'h53, 8'h52},
        '{8'h45, 8'h32, 8'h55, 8'h31}
    };

    typedef struct packed {
        logic  pressed;
        t_code code;
    } t_scan;

    typedef struct packed {
        logic adv;
        t_req req;
    } t_step_ctl;

endpackage

// ===== hdl/kpd_decode.sv =====
// Combinational decode of the column samples into a press flag and key code.
module kpd_decode (
    input  logic [kpd_pkg::CHECK_W-1:0] i_check_columns,
    input  logic [kpd_pkg::SCAN_W-1:0]  i_scan_columns,
    output kpd_pkg::t_scan              o_scan
);

    kpd_pkg::t_code code;

    always_comb begin
        code = '0;
        // The last low position in row-major order wins.
        for (int r = 0; r < kpd_pkg::ROWS; r++) begin
            for (int c = 0; c < kpd_pkg::COLUMNS; c++) begin
                if (!i_scan_columns[kpd_pkg::ROW_PITCH*r + c]) begin
                    code = kpd_pkg::CODE_TABLE[r][c];
                end
            end
        end
    end

    assign o_scan.pressed = ~&i_check_columns[kpd_pkg::COLUMNS-1:0];
    assign o_scan.code    = code;

endmodule

// ===== hdl/kpd_debounce.sv =====
// Debounce counter, previous code, latched key and the limit register.
`include "matrix_keypad_debounce_scanner_macros.svh"

module kpd_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [kpd_pkg::COUNT_W-1:0] i_cfg_wr_data,
    input  kpd_pkg::t_step_ctl          i_ctl,
    input  kpd_pkg::t_scan              i_scan,
    output kpd_pkg::t_code              o_latched_key
);

    logic [kpd_pkg::COUNT_W-1:0] r_limit;
    logic [kpd_pkg::COUNT_W-1:0] r_count, n_count;
    kpd_pkg::t_code              r_prev, n_prev;
    kpd_pkg::t_code              r_latched, n_latched;
    logic [kpd_pkg::COUNT_W-1:0] lim;

    assign lim = (r_limit > kpd_pkg::LIMIT_MAX) ? kpd_pkg::LIMIT_MAX : r_limit;

    always_comb begin
        n_count   = r_count;
        n_prev    = r_prev;
        n_latched = r_latched;
        if (i_ctl.adv) begin
            if (i_ctl.req == kpd_pkg::REQ_READ) begin
                n_latched = '0;
            end else if (!i_scan.pressed) begin
                n_count = '0;
            end else if (i_scan.code != r_prev) begin
                n_prev  = i_scan.code;
                n_count = '0;
            end else if (r_count == lim) begin
                // Park past the limit so the same code latches only once.
                n_count   = kpd_pkg::COUNT_W'(lim + kpd_pkg::PARK_OFFSET);
                n_latched = i_scan.code;
            end else if (r_count < lim) begin
                n_count = kpd_pkg::COUNT_W'(r_count + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= kpd_pkg::LIMIT_RESET;
            r_count   <= '0;
            r_prev    <= '0;
            r_latched <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_count   <= n_count;
            r_prev    <= n_prev;
            r_latched <= n_latched;
        end
    end

    assign o_latched_key = r_latched;

    `KPD_ASSERT_NXT(a_read_clears, i_clk, i_rst_n, i_ctl.adv && i_ctl.req == kpd_pkg::REQ_READ, r_latched == '0, "read did not clear the latched key")
    `KPD_ASSERT_NXT(a_release_clears, i_clk, i_rst_n, i_ctl.adv && i_ctl.req == kpd_pkg::REQ_SCAN && !i_scan.pressed, r_count == '0, "release did not clear the counter")
    `KPD_ASSERT_NXT(a_idle_holds, i_clk, i_rst_n, !i_ctl.adv, $stable(r_latched) && $stable(r_count) && $stable(r_prev), "state changed without a request")
    `KPD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= kpd_pkg::LIMIT_MAX + kpd_pkg::PARK_OFFSET, "counter beyond the parked value")

endmodule

// ===== hdl/matrix_keypad_debounce_scanner.sv =====
// Top level of the debounced 2x4 keypad scanner: input and result registers.
//
//  channel   dir  width  contents
//  s_axis    in   12+1   tdata: check_columns, scan_columns; tuser: req_type
//  m_axis    out  8      tdata: key_code (one per read request)
//  cfg       in   7      debounce_limit, written when i_cfg_wr_en is high
//
// A request is registered on acceptance; a read result passes the input and then
// the result register, and one request enters per cycle unless a read is held.
// Scan requests produce no result and never wait on the output. A read waits in
// the input register only while the result register is full and stalled. Reset
// is synchronous and clears all control state and the counter.
`include "matrix_keypad_debounce_scanner_macros.svh"

module matrix_keypad_debounce_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] check_columns, [11:4] scan_columns, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] key_code
);

    logic                        r_in_valid;
    kpd_pkg::t_req               r_in_req;
    logic [kpd_pkg::CHECK_W-1:0] r_in_check;
    logic [kpd_pkg::SCAN_W-1:0]  r_in_scan;
    logic                        r_out_valid;
    kpd_pkg::t_code              r_out_code;

    logic               out_free;
    logic               adv;
    kpd_pkg::t_step_ctl ctl;
    kpd_pkg::t_scan     scan;
    kpd_pkg::t_code     latched_key;

    assign out_free = !r_out_valid || m_axis_tready;
    assign adv      = r_in_valid && ((r_in_req == kpd_pkg::REQ_SCAN) || out_free);
    assign s_axis_tready = !r_in_valid || adv;

    assign ctl.adv = adv;
    assign ctl.req = r_in_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv && r_in_req == kpd_pkg::REQ_READ) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req   <= kpd_pkg::t_req'(s_axis_tuser[0]);
            r_in_check <= s_axis_tdata[3:0];
            r_in_scan  <= s_axis_tdata[11:4];
        end
        if (adv && r_in_req == kpd_pkg::REQ_READ) begin
            r_out_code <= latched_key;
        end
    end

    kpd_decode u_decode (
        .i_check_columns (r_in_check),
        .i_scan_columns  (r_in_scan),
        .o_scan          (scan)
    );

    kpd_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctl         (ctl),
        .i_scan        (scan),
        .o_latched_key (latched_key)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_code;

    `KPD_ASSERT_NXT(a_held_request, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_in_req), "held request lost from the input register")
    `KPD_ASSERT_IMP(a_read_needs_room, i_clk, i_rst_n, adv && r_in_req == kpd_pkg::REQ_READ, out_free, "read result would overwrite a pending result")
    `KPD_ASSERT_IMP(a_scan_never_waits, i_clk, i_rst_n, r_in_valid && r_in_req == kpd_pkg::REQ_SCAN, adv, "scan request stalled")

endmodule
